### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Defining NO_ASSERTIONS compiles them
// away. The macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/carl_pkg.sv
// ---------------------------------------------------------------------------
// carl_pkg
// Types and constants shared by the command link sender modules.
// ---------------------------------------------------------------------------
package carl_pkg;

  // Default depth of the result queue.
  localparam int unsigned RESULT_QUEUE_DEPTH_DEF = 4;

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_USER_W = 1;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RETRY_LIMIT = 1'b1;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd3;

  // Result types held in the queue.
  localparam logic RES_ACK     = 1'b0;
  localparam logic RES_TIMEOUT = 1'b1;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_ACK    = 2'd2,
    KIND_TAKE   = 2'd3
  } kind_e;

  // Link state: no command, command waiting for the radio, waiting for an ack.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READY = 3'b010,
    ST_WAIT  = 3'b100
  } link_state_e;

  // One input item.
  typedef struct packed {
    kind_e       kind;
    logic        frame_good;
    logic [15:0] cmd_id;
    logic [7:0]  actuator_sel;
    logic [7:0]  ack_code;
    logic [15:0] ack_actual;
    logic [31:0] now_ms;
    logic        radio_ready;
  } item_t;

  // One queued result entry.
  typedef struct packed {
    logic        kind;
    logic [15:0] cmd_id;
    logic [7:0]  actuator;
    logic        ack_code;
    logic [15:0] actual;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // Push request from the link control to the queue.
  typedef struct packed {
    logic    en;
    result_t entry;
  } push_t;

  // Per-item status from the link control.
  typedef struct packed {
    logic        accepted;
    logic        send_now;
    logic [3:0]  send_retry;
    logic [15:0] send_cmd_id;
    logic        busy;
  } ctrl_out_t;

  // Per-item status from the queue.
  typedef struct packed {
    logic    took;
    logic    dropped;
    result_t taken;
  } queue_stat_t;

endpackage

### rtl/carl_ram.sv
// ---------------------------------------------------------------------------
// carl_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module carl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; contents have no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/carl_queue.sv
// ---------------------------------------------------------------------------
// carl_queue
// Result FIFO: head and fill counters around a RAM. The RAM always reads the
// head that the next item will see; a write to that slot is bypassed.
// ---------------------------------------------------------------------------
module carl_queue import carl_pkg::*; #(
  parameter int unsigned DEPTH = RESULT_QUEUE_DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned FW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  logic          take_i,
  input  push_t         push_i,
  output queue_stat_t   stat_o,
  output logic [FW-1:0] level_o
);

  localparam int unsigned SW = FW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  result_t       byp_q, byp_d;
  logic          byp_use_q, byp_use_d;
  logic          full, pop, wr_en;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] wr_addr;
  result_t       rd_data, head_entry;

  assign full = (fill_q == DEPTH_F);
  assign pop  = step_en_i && take_i && (fill_q != '0);

  // Tail slot is head plus fill, wrapped once.
  assign slot_sum = SW'(head_q) + SW'(fill_q);
  assign wr_addr  = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);
  assign wr_en    = step_en_i && push_i.en && !full;

  // Counter updates.
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (pop) begin
      head_d = (head_q == LAST_A) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end else if (wr_en) begin
      fill_d = fill_q + 1'b1;
    end
  end

  // Bypass when the slot written now is the one read for the next item.
  assign byp_use_d = wr_en && (wr_addr == head_d);
  assign byp_d     = byp_use_d ? push_i.entry : byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      byp_use_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      fill_q    <= fill_d;
      byp_use_q <= byp_use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= byp_d;
  end

  carl_ram #(
    .WIDTH (RESULT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (push_i.entry),
    .raddr_i (head_d),
    .rdata_o (rd_data)
  );

  assign head_entry = byp_use_q ? byp_q : rd_data;

  // Status of this item; taken fields are zero unless a result was popped.
  always_comb begin
    stat_o.took    = pop;
    stat_o.dropped = step_en_i && push_i.en && full;
    stat_o.taken   = pop ? head_entry : '0;
  end

  assign level_o = fill_d;

endmodule

### rtl/carl_ctrl.sv
// ---------------------------------------------------------------------------
// carl_ctrl
// Stop-and-wait control: holds the pending command, sends it on ticks,
// re-sends after the ack timeout and gives up after the retry limit.
// ---------------------------------------------------------------------------
module carl_ctrl import carl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_en_i,
  input  item_t       item_i,
  input  logic [15:0] ack_timeout_i,
  input  logic [3:0]  retry_limit_i,
  output push_t       push_o,
  output ctrl_out_t   ctrl_o
);

  link_state_e state_q, state_d;
  logic [15:0] pend_id_q, pend_id_d;
  logic [7:0]  pend_act_q, pend_act_d;
  logic [3:0]  retry_q, retry_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] elapsed;
  logic        timed_out, ack_match;

  // Wrap-safe elapsed time; a negative difference is not a timeout.
  assign elapsed   = item_i.now_ms - sent_q;
  assign timed_out = !elapsed[31] && (elapsed >= 32'(ack_timeout_i));
  assign ack_match = item_i.frame_good && (item_i.cmd_id == pend_id_q)
                     && (item_i.ack_code[7:1] == '0);

  always_comb begin
    state_d    = state_q;
    pend_id_d  = pend_id_q;
    pend_act_d = pend_act_q;
    retry_d    = retry_q;
    sent_d     = sent_q;
    push_o     = '0;
    ctrl_o     = '0;
    push_o.entry.cmd_id   = pend_id_q;
    push_o.entry.actuator = pend_act_q;
    if (step_en_i) begin
      case (item_i.kind)
        KIND_SUBMIT: begin
          if (item_i.frame_good && state_q == ST_IDLE) begin
            pend_id_d       = item_i.cmd_id;
            pend_act_d      = item_i.actuator_sel;
            retry_d         = '0;
            state_d         = ST_READY;
            ctrl_o.accepted = 1'b1;
          end
        end
        KIND_TICK: begin
          case (state_q)
            ST_READY: begin
              if (item_i.radio_ready) begin
                state_d            = ST_WAIT;
                sent_d             = item_i.now_ms;
                ctrl_o.send_now    = 1'b1;
                ctrl_o.send_retry  = retry_q;
                ctrl_o.send_cmd_id = pend_id_q;
              end
            end
            ST_WAIT: begin
              if (timed_out) begin
                if (retry_q < retry_limit_i) begin
                  retry_d = retry_q + 1'b1;
                  state_d = ST_READY;
                  if (item_i.radio_ready) begin
                    state_d            = ST_WAIT;
                    sent_d             = item_i.now_ms;
                    ctrl_o.send_now    = 1'b1;
                    ctrl_o.send_retry  = retry_d;
                    ctrl_o.send_cmd_id = pend_id_q;
                  end
                end else begin
                  // Out of retries: queue a timeout result.
                  push_o.en          = 1'b1;
                  push_o.entry.kind  = RES_TIMEOUT;
                  state_d            = ST_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        KIND_ACK: begin
          if (state_q != ST_IDLE && ack_match) begin
            push_o.en             = 1'b1;
            push_o.entry.kind     = RES_ACK;
            push_o.entry.ack_code = item_i.ack_code[0];
            push_o.entry.actual   = item_i.ack_actual;
            state_d               = ST_IDLE;
          end
        end
        default: ;
      endcase
    end
    ctrl_o.busy = (state_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q  <= pend_id_d;
    pend_act_q <= pend_act_d;
    retry_q    <= retry_d;
    sent_q     <= sent_d;
  end

endmodule

### rtl/command_ack_retry_link.sv
// ---------------------------------------------------------------------------
// command_ack_retry_link
// Stop-and-wait command sender with retry limit and a result queue.
// ---------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser gives the kind (submit, tick, ack,
// take) and tdata the parsed fields. Every item produces exactly one result
// item on the m_axis channel, carrying the submit/take acceptance, any radio
// send, the taken result (its type in tuser), the busy flag, the queue level
// and the drop flag.
// An accepted item is held in an input register and evaluated into the
// result register once that register is free; its result is then offered
// on m_axis. One item per cycle is sustained while the receiver does not
// stall; the evaluation is a single pass of compares and one queue access.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; tready falls only when both are full.
// The user must write the timeout and retry limit on the cfg port only while
// idle; the block does not enforce this. Reset leaves no pending command, an
// empty queue, a 1000 ms timeout, retry limit 3; entries need no clearing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module command_ack_retry_link import carl_pkg::*; #(
  parameter int unsigned RESULT_QUEUE_DEPTH = RESULT_QUEUE_DEPTH_DEF,
  localparam int unsigned LVL_W      = $clog2(RESULT_QUEUE_DEPTH + 1),
  localparam int unsigned OUT_BITS   = 65 + LVL_W,
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave side.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: frame_good, cmd_id, actuator_sel, ack_code, ack_actual, now_ms,
  // radio_ready, zero fill.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind.
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // Master side.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: accepted, send_now, send_retry, send_cmd_id, out_cmd_id,
  // out_actuator, out_ack_code, out_actual, busy_res, queue_level,
  // queue_dropped, zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: out_kind.
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Result register contents.
  typedef struct packed {
    logic        accepted;
    logic        send_now;
    logic [3:0]  send_retry;
    logic [15:0] send_cmd_id;
    logic        out_kind;
    logic [15:0] out_cmd_id;
    logic [7:0]  out_actuator;
    logic        out_ack_code;
    logic [15:0] out_actual;
    logic        busy_res;
    logic        queue_dropped;
  } res_t;

  logic        [15:0] ack_timeout_q;
  logic        [3:0]  retry_limit_q;
  item_t              in_q, in_d;
  logic               in_vld_q, in_vld_d;
  res_t               res_q, res_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               res_vld_q, res_vld_d;
  logic               s_fire, m_fire, step_en;
  push_t              push;
  ctrl_out_t          ctrl;
  queue_stat_t        qstat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i;
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Handshake: an item is evaluated when the result register is free.
  assign step_en       = in_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step_en;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  // Input register unpacking.
  always_comb begin
    in_d = in_q;
    if (s_fire) begin
      in_d.kind         = kind_e'(s_axis_tuser);
      in_d.frame_good   = s_axis_tdata[0];
      in_d.cmd_id       = s_axis_tdata[16:1];
      in_d.actuator_sel = s_axis_tdata[24:17];
      in_d.ack_code     = s_axis_tdata[32:25];
      in_d.ack_actual   = s_axis_tdata[48:33];
      in_d.now_ms       = s_axis_tdata[80:49];
      in_d.radio_ready  = s_axis_tdata[81];
    end
  end

  assign in_vld_d  = s_fire ? 1'b1 : (step_en ? 1'b0 : in_vld_q);
  assign res_vld_d = step_en ? 1'b1 : (m_fire ? 1'b0 : res_vld_q);

  carl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (step_en),
    .item_i        (in_q),
    .ack_timeout_i (ack_timeout_q),
    .retry_limit_i (retry_limit_q),
    .push_o        (push),
    .ctrl_o        (ctrl)
  );

  carl_queue #(
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .take_i    (in_q.kind == KIND_TAKE),
    .push_i    (push),
    .stat_o    (qstat),
    .level_o   (lvl_d)
  );

  // Result assembly.
  always_comb begin
    res_d = res_q;
    if (step_en) begin
      res_d.accepted      = ctrl.accepted || qstat.took;
      res_d.send_now      = ctrl.send_now;
      res_d.send_retry    = ctrl.send_retry;
      res_d.send_cmd_id   = ctrl.send_cmd_id;
      res_d.out_kind      = qstat.taken.kind;
      res_d.out_cmd_id    = qstat.taken.cmd_id;
      res_d.out_actuator  = qstat.taken.actuator;
      res_d.out_ack_code  = qstat.taken.ack_code;
      res_d.out_actual    = qstat.taken.actual;
      res_d.busy_res      = ctrl.busy;
      res_d.queue_dropped = qstat.dropped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    res_q <= res_d;
    if (step_en) begin
      lvl_q <= lvl_d;
    end
  end

  // Output packing.
  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tuser  = res_q.out_kind;
  assign m_axis_tdata  = OUT_DATA_W'({
    res_q.queue_dropped, lvl_q, res_q.busy_res, res_q.out_actual,
    res_q.out_ack_code, res_q.out_actuator, res_q.out_cmd_id,
    res_q.send_cmd_id, res_q.send_retry, res_q.send_now, res_q.accepted
  });

  // Assertions.
  `ASSERT_PROP(a_level_bound, lvl_d <= LVL_W'(RESULT_QUEUE_DEPTH),
               "queue level above depth")
  `ASSERT_NEVER(a_send_and_accept, res_vld_q && res_q.send_now && res_q.accepted,
                "send and accept reported for one item")
  `ASSERT_PROP(a_drop_when_full,
               (res_vld_q && res_q.queue_dropped) |-> (lvl_q == LVL_W'(RESULT_QUEUE_DEPTH)),
               "result dropped while queue not full")
  `ASSERT_PROP(a_step_gives_result, step_en |=> res_vld_q,
               "evaluated item did not reach the result register")

endmodule
